// ===== hdl/bis_pkg.sv =====
// shared types, constants and helpers of the bilinear image scaler
`timescale 1ns / 1ps
package bis_pkg;

   localparam int CHANNELS    = 4;
   localparam int PIX_W       = 32;
   localparam int CH_W        = 8;
   localparam int SRC_DIM_W   = 7;
   localparam int OUT_DIM_W   = 9;
   localparam int COORD_W     = 8;
   localparam int STEP_W      = 22;
   localparam int FRAC_W      = 16;
   localparam int POS_W       = COORD_W + STEP_W;
   localparam int FLOOR_W     = POS_W - FRAC_W;
   localparam int LIN_W       = 2 * SRC_DIM_W;
   localparam int WGT_W       = FRAC_W + 1;
   localparam int ROWMIX_W    = CH_W + FRAC_W;
   localparam int FULLMIX_W   = ROWMIX_W + WGT_W;
   localparam int LOAD_IDX_W  = 12;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 22;
   localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(1) << FRAC_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH  = 3'd0,
      CSR_SOURCE_HEIGHT = 3'd1,
      CSR_OUTPUT_WIDTH  = 3'd2,
      CSR_OUTPUT_HEIGHT = 3'd3,
      CSR_COLUMN_STEP   = 3'd4,
      CSR_ROW_STEP      = 3'd5
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   typedef struct packed {
      logic valid;
      logic bad;
   } ctl_type;

   function automatic logic [SRC_DIM_W-1:0] eff_size(logic [SRC_DIM_W-1:0] v, int maxv);
      logic [SRC_DIM_W-1:0] r;
      if (v == '0) begin
         r = SRC_DIM_W'(1);
      end else if (int'(v) > maxv) begin
         r = SRC_DIM_W'(maxv);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== hdl/bis_ram.sv =====
// generic simple ram, one write port and two registered read ports
`timescale 1ns / 1ps
module bis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hdl/bis_addr.sv =====
// source position, neighbour addresses and weights for one query
`timescale 1ns / 1ps
module bis_addr import bis_pkg::*; #(
   parameter int AW = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  query,
   input  logic [COORD_W-1:0]    out_row,
   input  logic [COORD_W-1:0]    out_col,
   input  logic [SRC_DIM_W-1:0]  src_w,
   input  logic [SRC_DIM_W-1:0]  src_h,
   input  logic [OUT_DIM_W-1:0]  out_w,
   input  logic [OUT_DIM_W-1:0]  out_h,
   input  logic [STEP_W-1:0]     col_step,
   input  logic [STEP_W-1:0]     row_step,
   output logic [AW-1:0]         addr_00,
   output logic [AW-1:0]         addr_10,
   output logic [AW-1:0]         addr_01,
   output logic [AW-1:0]         addr_11,
   output logic [FRAC_W-1:0]     frac_r,
   output logic [FRAC_W-1:0]     frac_c,
   output ctl_type               ctl
);

   ctl_type                ctl1_ff, ctl1_in;
   ctl_type                ctl2_ff;
   logic [POS_W-1:0]       pos_r_ff, pos_c_ff;
   logic [FRAC_W-1:0]      fr_ff, fc_ff;
   logic [FRAC_W-1:0]      fr_in, fc_in;
   logic [SRC_DIM_W-1:0]   r0, r1, c0, c1, last_r, last_c;
   logic [LIN_W-1:0]       base, base_hi;

   always_comb begin
      ctl1_in.valid = query;
      ctl1_in.bad   = ({1'b0, out_row} >= out_h) || ({1'b0, out_col} >= out_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
      end
      pos_r_ff <= POS_W'(out_row) * POS_W'(row_step);
      pos_c_ff <= POS_W'(out_col) * POS_W'(col_step);
      fr_ff    <= fr_in;
      fc_ff    <= fc_in;
   end

   always_comb begin
      last_r = src_h - SRC_DIM_W'(1);
      last_c = src_w - SRC_DIM_W'(1);
      if (FLOOR_W'(last_r) <= pos_r_ff[POS_W-1:FRAC_W]) begin
         r0    = last_r;
         r1    = last_r;
         fr_in = '0;
      end else begin
         r0    = pos_r_ff[FRAC_W +: SRC_DIM_W];
         fr_in = pos_r_ff[FRAC_W-1:0];
         r1    = (fr_in != '0) ? r0 + SRC_DIM_W'(1) : r0;
      end
      if (FLOOR_W'(last_c) <= pos_c_ff[POS_W-1:FRAC_W]) begin
         c0    = last_c;
         c1    = last_c;
         fc_in = '0;
      end else begin
         c0    = pos_c_ff[FRAC_W +: SRC_DIM_W];
         fc_in = pos_c_ff[FRAC_W-1:0];
         c1    = (fc_in != '0) ? c0 + SRC_DIM_W'(1) : c0;
      end
      base    = LIN_W'(r0) * LIN_W'(src_w);
      base_hi = base + ((r1 != r0) ? LIN_W'(src_w) : '0);
   end

   assign addr_00 = AW'(base + LIN_W'(c0));
   assign addr_01 = AW'(base + LIN_W'(c1));
   assign addr_10 = AW'(base_hi + LIN_W'(c0));
   assign addr_11 = AW'(base_hi + LIN_W'(c1));
   assign frac_r  = fr_ff;
   assign frac_c  = fc_ff;
   assign ctl     = ctl2_ff;

endmodule

// ===== hdl/bis_blend.sv =====
// per channel row blend then column blend, result register
`timescale 1ns / 1ps
module bis_blend import bis_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   input  logic [FRAC_W-1:0]  frac_r,
   input  logic [FRAC_W-1:0]  frac_c,
   input  logic [PIX_W-1:0]   p00,
   input  logic [PIX_W-1:0]   p10,
   input  logic [PIX_W-1:0]   p01,
   input  logic [PIX_W-1:0]   p11,
   output logic               rsp_valid,
   output logic [PIX_W-1:0]   rsp_pixel_out,
   output logic               rsp_bad_request
);

   ctl_type                 ctl_ff;
   logic [FRAC_W-1:0]       fc_ff;
   logic [ROWMIX_W-1:0]     q1_ff [CHANNELS];
   logic [ROWMIX_W-1:0]     q2_ff [CHANNELS];
   logic [ROWMIX_W-1:0]     q1_in [CHANNELS];
   logic [ROWMIX_W-1:0]     q2_in [CHANNELS];
   logic [PIX_W-1:0]        pix_in, pix_ff;
   logic                    valid_ff, bad_ff;
   logic [WGT_W-1:0]        wr_hi, wr_lo, wc_hi, wc_lo;
   logic [FULLMIX_W-1:0]    mix;

   always_comb begin
      wr_hi = WGT_W'(frac_r);
      wr_lo = ONE_Q16 - wr_hi;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         q1_in[ch] = ROWMIX_W'(p00[ch*CH_W +: CH_W]) * ROWMIX_W'(wr_lo)
                   + ROWMIX_W'(p10[ch*CH_W +: CH_W]) * ROWMIX_W'(wr_hi);
         q2_in[ch] = ROWMIX_W'(p01[ch*CH_W +: CH_W]) * ROWMIX_W'(wr_lo)
                   + ROWMIX_W'(p11[ch*CH_W +: CH_W]) * ROWMIX_W'(wr_hi);
      end
   end

   always_comb begin
      wc_hi  = WGT_W'(fc_ff);
      wc_lo  = ONE_Q16 - wc_hi;
      pix_in = '0;
      mix    = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         mix = FULLMIX_W'(q1_ff[ch]) * FULLMIX_W'(wc_lo)
             + FULLMIX_W'(q2_ff[ch]) * FULLMIX_W'(wc_hi);
         pix_in[ch*CH_W +: CH_W] = mix[2*FRAC_W +: CH_W];
      end
      if (!ctl_ff.valid || ctl_ff.bad) begin
         pix_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '0;
         valid_ff <= 1'b0;
         bad_ff   <= 1'b0;
      end else begin
         ctl_ff   <= ctl;
         valid_ff <= ctl_ff.valid;
         bad_ff   <= ctl_ff.valid && ctl_ff.bad;
      end
      fc_ff  <= frac_c;
      q1_ff  <= q1_in;
      q2_ff  <= q2_in;
      pix_ff <= pix_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_out   = pix_ff;
   assign rsp_bad_request = bad_ff;

endmodule

// ===== hdl/bilinear_image_scaler.sv =====
// top level of the bilinear image scaler
// usage:
//  - csr port: write csr_write_data to register csr_index while csr_write_enable
//    is high; 0 source width, 1 source height, 2 output width, 3 output height,
//    4 column step, 5 row step (steps unsigned q6.16); write only while idle
//  - request channel: a transfer happens when start is high and busy is low;
//    busy stays low, so one item can be taken every cycle
//  - a load (req_kind low) writes req_pixel_in at req_load_index, no response
//  - a query (req_kind high) asks for output pixel req_out_row, req_out_col
//  - the response shows on rsp_* with rsp_valid high for exactly one cycle,
//    after the query transfer has passed the registers of the pipeline stages:
//    position products, pixel store read, row blend, column blend register
//  - throughput is one item per cycle; the four neighbours come from two copies
//    of the pixel store, each with two read ports, both written on every load
//  - a load right after a query does not disturb that query (read-first store)
//  - reset clears the pipeline and sets registers to 64x64 source, 64x64 out,
//    unit steps; the pixel store is not cleared
//  - the receiver takes every response, there is no back-pressure
`timescale 1ns / 1ps
module bilinear_image_scaler import bis_pkg::*; #(
   parameter int MAX_SOURCE_WIDTH  = 64,
   parameter int MAX_SOURCE_HEIGHT = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_kind,
   input  logic [LOAD_IDX_W-1:0]  req_load_index,
   input  logic [PIX_W-1:0]       req_pixel_in,
   input  logic [COORD_W-1:0]     req_out_row,
   input  logic [COORD_W-1:0]     req_out_col,
   output logic                   rsp_valid,
   output logic [PIX_W-1:0]       rsp_pixel_out,
   output logic                   rsp_bad_request,
   input  logic                   csr_write_enable,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   logic [SRC_DIM_W-1:0] src_w_ff, src_h_ff, src_w_eff, src_h_eff;
   logic [OUT_DIM_W-1:0] out_w_ff, out_h_ff;
   logic [STEP_W-1:0]    col_step_ff, row_step_ff;
   logic                 accept, load_wr;
   logic [AW-1:0]        a00, a10, a01, a11;
   logic [PIX_W-1:0]     p00, p10, p01, p11;
   logic [FRAC_W-1:0]    frac_r, frac_c;
   ctl_type              ctl;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign load_wr = accept && (req_kind == KIND_LOAD) && (int'(req_load_index) < DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff    <= SRC_DIM_W'(64);
         src_h_ff    <= SRC_DIM_W'(64);
         out_w_ff    <= OUT_DIM_W'(64);
         out_h_ff    <= OUT_DIM_W'(64);
         col_step_ff <= STEP_W'(65536);
         row_step_ff <= STEP_W'(65536);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  src_w_ff    <= csr_write_data[SRC_DIM_W-1:0];
            CSR_SOURCE_HEIGHT: src_h_ff    <= csr_write_data[SRC_DIM_W-1:0];
            CSR_OUTPUT_WIDTH:  out_w_ff    <= csr_write_data[OUT_DIM_W-1:0];
            CSR_OUTPUT_HEIGHT: out_h_ff    <= csr_write_data[OUT_DIM_W-1:0];
            CSR_COLUMN_STEP:   col_step_ff <= csr_write_data[STEP_W-1:0];
            CSR_ROW_STEP:      row_step_ff <= csr_write_data[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign src_w_eff = eff_size(src_w_ff, MAX_SOURCE_WIDTH);
   assign src_h_eff = eff_size(src_h_ff, MAX_SOURCE_HEIGHT);

   bis_addr #(.AW(AW)) u_addr (
      .clock    (clock),
      .reset    (reset),
      .query    (accept && (req_kind == KIND_QUERY)),
      .out_row  (req_out_row),
      .out_col  (req_out_col),
      .src_w    (src_w_eff),
      .src_h    (src_h_eff),
      .out_w    (out_w_ff),
      .out_h    (out_h_ff),
      .col_step (col_step_ff),
      .row_step (row_step_ff),
      .addr_00  (a00),
      .addr_10  (a10),
      .addr_01  (a01),
      .addr_11  (a11),
      .frac_r   (frac_r),
      .frac_c   (frac_c),
      .ctl      (ctl)
   );

   bis_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram_c0 (
      .clock     (clock),
      .wr_en     (load_wr),
      .wr_addr   (AW'(req_load_index)),
      .wr_data   (req_pixel_in),
      .rd_addr_a (a00),
      .rd_addr_b (a10),
      .rd_data_a (p00),
      .rd_data_b (p10)
   );

   bis_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram_c1 (
      .clock     (clock),
      .wr_en     (load_wr),
      .wr_addr   (AW'(req_load_index)),
      .wr_data   (req_pixel_in),
      .rd_addr_a (a01),
      .rd_addr_b (a11),
      .rd_data_a (p01),
      .rd_data_b (p11)
   );

   bis_blend u_blend (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .frac_r          (frac_r),
      .frac_c          (frac_c),
      .p00             (p00),
      .p10             (p10),
      .p01             (p01),
      .p11             (p11),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_bad_request (rsp_bad_request)
   );

endmodule

// ===== hdl/bis_checker.sv =====
// port level checks of the bilinear image scaler, bound to the top level
`timescale 1ns / 1ps
module bis_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic [31:0] rsp_pixel_out,
   input logic        rsp_bad_request
);

   logic query;
   assign query = start && !busy && req_kind;

   a_rsp_has_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(query, 4))
      else $error("response without a query transfer");

   a_query_gets_rsp: assert property (@(posedge clock)
      $past(query, 3) && !$past(reset, 3) && !$past(reset, 2) && !$past(reset, 1)
      && !reset |=> rsp_valid)
      else $error("query transfer lost");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bad_request |-> (rsp_pixel_out == 32'd0) && rsp_valid)
      else $error("flagged response carries data");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> (rsp_pixel_out == 32'd0) && !rsp_bad_request)
      else $error("response ports active without strobe");

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_kind        (req_kind),
   .rsp_valid       (rsp_valid),
   .rsp_pixel_out   (rsp_pixel_out),
   .rsp_bad_request (rsp_bad_request)
);

// ===== sim/tb_bilinear_image_scaler.sv =====
// self-checking testbench of the bilinear image scaler
`timescale 1ns / 1ps
module tb_bilinear_image_scaler;
   import bis_pkg::*;

   localparam int STORE_DEPTH  = 4096;
   localparam int FILL_DEPTH   = 512;
   localparam int MAX_SRC      = 64;
   localparam int STALL_LIMIT  = 300;
   localparam int RANDOM_ITEMS = 48;
   localparam int NUM_PHASES   = 11;

   typedef struct {
      logic [PIX_W-1:0] pixel;
      logic             bad;
   } pixel_result_type;

   typedef struct {
      kind_type               kind;
      logic [LOAD_IDX_W-1:0]  index;
      logic [PIX_W-1:0]       pixel;
      logic [COORD_W-1:0]     row;
      logic [COORD_W-1:0]     col;
      logic                   typed;
      logic [PIX_W-1:0]       exp_pixel;
      logic                   exp_bad;
   } scaler_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_kind = 1'b0;
   logic [LOAD_IDX_W-1:0] req_load_index = '0;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic [COORD_W-1:0]    req_out_row = '0;
   logic [COORD_W-1:0]    req_out_col = '0;
   logic                  rsp_valid;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_bad_request;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   logic [PIX_W-1:0]      shadow_pixels [STORE_DEPTH];
   logic [6:0]            cfg_src_width = 7'd64;
   logic [6:0]            cfg_src_height = 7'd64;
   logic [8:0]            cfg_out_width = 9'd64;
   logic [8:0]            cfg_out_height = 9'd64;
   logic [21:0]           cfg_col_step = 22'd65536;
   logic [21:0]           cfg_row_step = 22'd65536;

   pixel_result_type      pending_pixels[$];
   int                    error_count = 0;
   int                    stall_cycles = 0;
   logic                  idle_enable = 1'b1;

   bilinear_image_scaler u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_load_index   (req_load_index),
      .req_pixel_in     (req_pixel_in),
      .req_out_row      (req_out_row),
      .req_out_col      (req_out_col),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_bad_request  (rsp_bad_request),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_size(input int unsigned v);
      int unsigned r;
      r = v;
      if (v == 0) r = 1;
      else if (v > MAX_SRC) r = MAX_SRC;
      return r;
   endfunction

   function automatic void resolve_axis(input int unsigned coord, input int unsigned step,
                                        input int unsigned size, output int unsigned lo,
                                        output int unsigned hi, output int unsigned frac);
      logic [63:0] pos;
      logic [63:0] fl;
      int unsigned f;
      int unsigned last;
      pos  = 64'(coord) * 64'(step);
      fl   = pos >> 16;
      f    = int'(pos[15:0]);
      last = size - 1;
      if (fl >= 64'(last)) begin
         lo = last;
         hi = last;
         frac = 0;
      end else begin
         lo = int'(fl);
         hi = (f != 0) ? lo + 1 : lo;
         if (hi > last) hi = last;
         frac = (hi == lo) ? 0 : f;
      end
   endfunction

   function automatic pixel_result_type scale_pixel(input logic [COORD_W-1:0] row,
                                                    input logic [COORD_W-1:0] col);
      pixel_result_type res;
      int unsigned sw, sh, r0, r1, fr, c0, c1, fc;
      logic [PIX_W-1:0] p00, p10, p01, p11;
      logic [63:0] q1, q2, v;
      res.pixel = '0;
      res.bad = 1'b0;
      if (row >= cfg_out_height || col >= cfg_out_width) begin
         res.bad = 1'b1;
         return res;
      end
      sw = clamp_size(cfg_src_width);
      sh = clamp_size(cfg_src_height);
      resolve_axis(row, cfg_row_step, sh, r0, r1, fr);
      resolve_axis(col, cfg_col_step, sw, c0, c1, fc);
      p00 = shadow_pixels[r0 * sw + c0];
      p10 = shadow_pixels[r1 * sw + c0];
      p01 = shadow_pixels[r0 * sw + c1];
      p11 = shadow_pixels[r1 * sw + c1];
      for (int ch = 0; ch < CHANNELS; ch++) begin
         q1 = 64'(p00[ch*8 +: 8]) * 64'(65536 - fr) + 64'(p10[ch*8 +: 8]) * 64'(fr);
         q2 = 64'(p01[ch*8 +: 8]) * 64'(65536 - fr) + 64'(p11[ch*8 +: 8]) * 64'(fr);
         v  = (q1 * 64'(65536 - fc) + q2 * 64'(fc)) >> 32;
         res.pixel[ch*8 +: 8] = v[7:0];
      end
      return res;
   endfunction

   // one transfer; start stays high for the caller to chain the next item
   task automatic send_item(input scaler_row_type it);
      pixel_result_type exp_res;
      start          <= 1'b1;
      req_kind       <= it.kind;
      req_load_index <= it.index;
      req_pixel_in   <= it.pixel;
      req_out_row    <= it.row;
      req_out_col    <= it.col;
      do @(posedge clock); while (busy);
      if (it.kind == KIND_LOAD) begin
         shadow_pixels[it.index] = it.pixel;
      end else if (it.typed) begin
         exp_res.pixel = it.exp_pixel;
         exp_res.bad = it.exp_bad;
         pending_pixels = {pending_pixels, exp_res};
      end else begin
         pending_pixels = {pending_pixels, scale_pixel(it.row, it.col)};
      end
   endtask

   task automatic maybe_idle();
      if (idle_enable && $urandom_range(99) < 20) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_SOURCE_WIDTH:  cfg_src_width = data[6:0];
         CSR_SOURCE_HEIGHT: cfg_src_height = data[6:0];
         CSR_OUTPUT_WIDTH:  cfg_out_width = data[8:0];
         CSR_OUTPUT_HEIGHT: cfg_out_height = data[8:0];
         CSR_COLUMN_STEP:   cfg_col_step = data[21:0];
         CSR_ROW_STEP:      cfg_row_step = data[21:0];
         default: ;
      endcase
   endtask

   function automatic scaler_row_type random_item();
      scaler_row_type it;
      it.kind  = ($urandom_range(99) < 22) ? KIND_LOAD : KIND_QUERY;
      it.index = LOAD_IDX_W'($urandom);
      it.pixel = $urandom;
      it.row   = COORD_W'($urandom);
      it.col   = COORD_W'($urandom);
      if ($urandom_range(3) != 0 && cfg_out_height != 0 && cfg_out_width != 0) begin
         it.row = COORD_W'($urandom_range((cfg_out_height > 256 ? 256 : cfg_out_height) - 1));
         it.col = COORD_W'($urandom_range((cfg_out_width > 256 ? 256 : cfg_out_width) - 1));
      end
      it.typed = 1'b0;
      it.exp_pixel = '0;
      it.exp_bad = 1'b0;
      return it;
   endfunction

   // response check
   always @(posedge clock) begin
      pixel_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected response pixel %h bad %b", $time, rsp_pixel_out,
                     rsp_bad_request);
            error_count++;
         end else begin
            exp_res = pending_pixels.pop_front();
            if (rsp_pixel_out !== exp_res.pixel) begin
               $display("%0t: pixel_out expected %h actual %h", $time, exp_res.pixel,
                        rsp_pixel_out);
               error_count++;
            end
            if (rsp_bad_request !== exp_res.bad) begin
               $display("%0t: bad_request expected %b actual %b", $time, exp_res.bad,
                        rsp_bad_request);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      scaler_row_type directed [16];
      scaler_row_type it;
      logic [21:0] phase_cfg [NUM_PHASES][6];
      int unsigned eff_w;
      directed = '{
         '{KIND_LOAD,  12'd0,    32'h0000_0000, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
         '{KIND_LOAD,  12'd4095, 32'hFFFF_FFFF, 8'd255, 8'd255, 1'b0, 32'h0, 1'b0},
         '{KIND_QUERY, 12'd4095, 32'hFFFF_FFFF, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
         '{KIND_QUERY, 12'd0,    32'h0,         8'd63,  8'd63,  1'b0, 32'h0, 1'b0},
         '{KIND_LOAD,  12'd1,    32'hFFFF_FFFF, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
         '{KIND_QUERY, 12'd0,    32'h0,         8'd0,   8'd1,   1'b0, 32'h0, 1'b0},
         '{KIND_QUERY, 12'd0,    32'h0,         8'd64,  8'd0,   1'b1, 32'h0, 1'b1},
         '{KIND_QUERY, 12'd0,    32'h0,         8'd0,   8'd64,  1'b1, 32'h0, 1'b1},
         '{KIND_QUERY, 12'd0,    32'h0,         8'd255, 8'd255, 1'b1, 32'h0, 1'b1},
         '{KIND_QUERY, 12'd0,    32'h0,         8'd0,   8'd255, 1'b1, 32'h0, 1'b1},
         '{KIND_LOAD,  12'd4032, 32'h1234_5678, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
         '{KIND_QUERY, 12'd0,    32'h0,         8'd63,  8'd0,   1'b0, 32'h0, 1'b0},
         '{KIND_LOAD,  12'd63,   32'h8040_2010, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
         '{KIND_QUERY, 12'd0,    32'h0,         8'd0,   8'd63,  1'b0, 32'h0, 1'b0},
         '{KIND_LOAD,  12'd2065, 32'hA5C3_0F96, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
         '{KIND_QUERY, 12'd0,    32'h0,         8'd32,  8'd17,  1'b0, 32'h0, 1'b0}
      };
      phase_cfg = '{
         '{22'd0,   22'd0,   22'd256, 22'd256, 22'd65536,   22'd65536},
         '{22'd127, 22'd8,   22'd511, 22'd511, 22'd4194303, 22'd4194303},
         '{22'd16,  22'd32,  22'd256, 22'd256, 22'd16384,   22'd16384},
         '{22'd13,  22'd7,   22'd40,  22'd20,  22'd21300,   22'd23000},
         '{22'd1,   22'd127, 22'd0,   22'd100, 22'd0,       22'd1},
         '{22'd64,  22'd1,   22'd100, 22'd1,   22'd1,       22'd0},
         '{22'd32,  22'd16,  22'd64,  22'd64,  22'd32768,   22'd98304},
         '{22'd2,   22'd2,   22'd1,   22'd1,   22'd65535,   22'd65537},
         '{22'd0,   22'd0,   22'd0,   22'd0,   22'd0,       22'd0},
         '{22'd0,   22'd0,   22'd0,   22'd0,   22'd0,       22'd0},
         '{22'd0,   22'd0,   22'd0,   22'd0,   22'd0,       22'd0}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the part of the store that every source size below can reach
      for (int i = 0; i < FILL_DEPTH; i++) begin
         it = random_item();
         it.kind = KIND_LOAD;
         it.index = LOAD_IDX_W'(i);
         send_item(it);
      end
      foreach (directed[i]) begin
         send_item(directed[i]);
         maybe_idle();
      end
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p >= 8) begin
            phase_cfg[p][0] = 22'($urandom_range(127));
            eff_w = clamp_size(32'(phase_cfg[p][0]));
            phase_cfg[p][1] = 22'($urandom_range((FILL_DEPTH / eff_w) > 127 ?
                                                 127 : FILL_DEPTH / eff_w));
            phase_cfg[p][2] = 22'($urandom_range(511));
            phase_cfg[p][3] = 22'($urandom_range(511));
            phase_cfg[p][4] = 22'($urandom);
            phase_cfg[p][5] = 22'($urandom_range(196608));
         end
         csr_write(CSR_SOURCE_WIDTH,  phase_cfg[p][0]);
         csr_write(CSR_SOURCE_HEIGHT, phase_cfg[p][1]);
         csr_write(CSR_OUTPUT_WIDTH,  phase_cfg[p][2]);
         csr_write(CSR_OUTPUT_HEIGHT, phase_cfg[p][3]);
         csr_write(CSR_COLUMN_STEP,   phase_cfg[p][4]);
         csr_write(CSR_ROW_STEP,      phase_cfg[p][5]);
         csr_write_enable <= 1'b0;
         idle_enable = (p != 2);
         for (int i = 0; i < RANDOM_ITEMS; i++) begin
            send_item(random_item());
            maybe_idle();
         end
         drain();
      end

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
